// ----- src/stepgen_pkg.sv -----
package stepgen_pkg;

    localparam int POS_BITS   = 24;
    localparam int TIMER_BITS = 20;
    localparam int STEPS_W    = 24;
    localparam int SCALE_W    = 6;
    localparam int PERIOD_W   = 20;
    localparam int HALF_W     = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    // signed product of steps and the zero-extended scale
    localparam int SCALED_W   = STEPS_W + SCALE_W + 1;
    // position plus scaled count, one bit of headroom
    localparam int TARGET_W   = SCALED_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_HOME = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_HOME = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_SETTLE = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2,
        PH_PAUSE  = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_POS  = 3'd0,
        REG_MAX_POS  = 3'd1,
        REG_SCALE    = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_HALF     = 3'd4,
        REG_REVERSE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] min_position;
        logic signed [POS_BITS-1:0] max_position;
        logic [SCALE_W-1:0]         step_scale;
        logic [PERIOD_W-1:0]        step_period;
        logic [HALF_W-1:0]          pulse_half;
        logic                       reverse_dir;
    } cfg_t;

    typedef struct packed {
        logic                       step_out;
        logic                       dir_out;
        logic                       awake_out;
        logic signed [POS_BITS-1:0] axis_position;
        logic                       busy_res;
        logic [STATUS_W-1:0]        status;
    } result_t;

endpackage

// ----- src/stepgen_core.sv -----
module stepgen_core
    import stepgen_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [CMD_W-1:0]          command,
    input  logic signed [STEPS_W-1:0] steps,
    input  logic                      home_sensor,
    input  cfg_t                      cfg,
    output result_t                   res
);

    logic [POS_BITS-1:0]   position_reg,  position_next;
    logic [POS_BITS-1:0]   remaining_reg, remaining_next;
    logic                  dir_reg,       dir_next;
    mode_t                 mode_reg,      mode_next;
    phase_t                phase_reg,     phase_next;
    logic [TIMER_BITS-1:0] timer_reg,     timer_next;
    logic                  awake_reg,     awake_next;
    status_t               status_now;

    logic signed [SCALED_W-1:0] scaled;
    logic signed [TARGET_W-1:0] target;
    logic [SCALED_W-1:0]        scaled_mag;
    logic                       out_of_window;
    logic [TIMER_BITS-1:0]      half_ticks;
    logic [TIMER_BITS-1:0]      period_ticks;

    assign half_ticks   = TIMER_BITS'(cfg.pulse_half);
    assign period_ticks = TIMER_BITS'(cfg.step_period);

    // move window check
    assign scaled        = steps * $signed({1'b0, cfg.step_scale});
    assign target        = TARGET_W'($signed(position_reg)) + TARGET_W'(scaled);
    assign out_of_window = (target > TARGET_W'(cfg.max_position))
                        || (target < TARGET_W'(cfg.min_position));
    assign scaled_mag    = scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);

    // next state
    always_comb
    begin
        logic do_tick;
        logic do_pulse;
        position_next  = position_reg;
        remaining_next = remaining_reg;
        dir_next       = dir_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        awake_next     = awake_reg;
        status_now     = ST_OK;
        do_tick        = 1'b0;
        do_pulse       = 1'b0;

        if ((command == CMD_MOVE) || (command == CMD_HOME))
        begin
            if (mode_reg != MODE_IDLE)
            begin
                status_now = ST_BUSY;
                do_tick    = 1'b1;
            end
            else if (command == CMD_MOVE)
            begin
                if (out_of_window)
                begin
                    status_now = ST_RANGE;
                end
                else
                begin
                    dir_next       = scaled[SCALED_W-1];
                    remaining_next = scaled_mag[POS_BITS-1:0];
                    mode_next      = MODE_MOVE;
                    phase_next     = PH_SETTLE;
                    timer_next     = half_ticks;
                end
            end
            else
            begin
                awake_next     = 1'b1;
                dir_next       = 1'b1;
                remaining_next = '0;
                mode_next      = MODE_HOME;
                phase_next     = PH_SETTLE;
                timer_next     = half_ticks;
            end
        end
        else
        begin
            do_tick = 1'b1;
        end

        if (do_tick && (mode_reg != MODE_IDLE))
        begin
            if (timer_reg > TIMER_BITS'(1))
            begin
                timer_next = timer_reg - TIMER_BITS'(1);
            end
            else
            begin
                unique case (phase_reg)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        timer_next = half_ticks;
                    end
                    PH_LOW:
                    begin
                        if (cfg.step_period == '0)
                        begin
                            do_pulse = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAUSE;
                            timer_next = period_ticks;
                        end
                    end
                    PH_SETTLE, PH_PAUSE:
                    begin
                        do_pulse = 1'b1;
                    end
                    default:
                    begin
                        do_pulse = 1'b1;
                    end
                endcase
            end
        end

        // end of settle or pause (or of the low phase when the period is zero): next pulse or finish
        if (do_pulse)
        begin
            if (mode_reg == MODE_MOVE)
            begin
                if (remaining_reg == '0)
                begin
                    mode_next  = MODE_IDLE;
                    phase_next = PH_SETTLE;
                    timer_next = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - POS_BITS'(1);
                    position_next  = dir_reg ? position_reg - POS_BITS'(1)
                                             : position_reg + POS_BITS'(1);
                    phase_next     = PH_HIGH;
                    timer_next     = half_ticks;
                end
            end
            else if (home_sensor)
            begin
                position_next = '0;
                awake_next    = 1'b0;
                mode_next     = MODE_IDLE;
                phase_next    = PH_SETTLE;
                timer_next    = '0;
            end
            else
            begin
                phase_next = PH_HIGH;
                timer_next = half_ticks;
            end
        end
    end

    // result fields seen after this item
    always_comb
    begin
        res.step_out      = (mode_next != MODE_IDLE) && (phase_next == PH_HIGH);
        res.dir_out       = dir_next ^ cfg.reverse_dir;
        res.awake_out     = awake_next;
        res.axis_position = $signed(position_next);
        res.busy_res      = (mode_next != MODE_IDLE);
        res.status        = status_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            remaining_reg <= '0;
            dir_reg       <= 1'b0;
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_SETTLE;
            timer_reg     <= '0;
            awake_reg     <= 1'b0;
        end
        else if (accept)
        begin
            position_reg  <= position_next;
            remaining_reg <= remaining_next;
            dir_reg       <= dir_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            awake_reg     <= awake_next;
        end
    end

    // idle always parks the sequencer
    a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (phase_reg == PH_SETTLE) && (timer_reg == '0))
        else $error("idle with sequencer not parked");

    // a rejected move leaves the position alone
    a_range_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_now == ST_RANGE)) |=> (position_reg == $past(position_reg))
                                               && (mode_reg == MODE_IDLE))
        else $error("out of range move changed state");

    // busy rejection only while a run is active
    a_busy_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_now == ST_BUSY)) |-> (mode_reg != MODE_IDLE))
        else $error("busy status while idle");

    // homing only ever clears the position
    a_home_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_HOME))
            |=> (position_reg == $past(position_reg)) || (position_reg == '0))
        else $error("position counted while homing");

    // the driver only sleeps again when homing finishes
    a_sleep_on_home: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(awake_reg) |-> ($past(mode_reg) == MODE_HOME) && (mode_reg == MODE_IDLE))
        else $error("driver put to sleep outside homing");

endmodule

// ----- src/stepper_axis_step_generator.sv -----
// step/direction generator for one stepper axis
//
// s_* channel: one transfer per 1 us tick; s_tuser carries the command
// (tick, move request, home request), s_tdata the step count and the home
// sensor level. every transfer, requests included, advances the timers by
// one tick and yields exactly one result transfer on the m_* channel.
// m_tdata carries the pin levels (step, dir, enable), the tracked position
// and the busy flag; m_tuser carries the request status.
//
// the result is registered in the output register, or in the skid on a stall; one item
// per cycle sustained while m_tready is high, by the single registered sequencer pass.
// a two-entry result queue (output register plus skid) keeps s_tready high after
// m_tready drops until the skid fills; s_tready falls only with both full.
//
// cfg_we/cfg_addr/cfg_wdata write the limit, scale, timing and reverse registers;
// write only while no run is active and all results are taken.
// reset: axis idle, driver asleep, position zero, result queue empty,
// registers at their documented defaults.
module stepper_axis_step_generator
    import stepgen_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // steps[23:0], home_sensor[24], zero fill
    input  logic [CMD_W-1:0]     s_tuser,   // command[1:0]
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // step_out[0], dir_out[1], awake_out[2],
                                            // axis_position[26:3], busy_res[27], zero fill
    output logic [STATUS_W-1:0]  m_tuser,   // status[1:0]
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t    cfg_reg;
    result_t res_now;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    s_accept;
    logic    out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_position <= POS_BITS'(0);
            cfg_reg.max_position <= POS_BITS'(2000);
            cfg_reg.step_scale   <= SCALE_W'(1);
            cfg_reg.step_period  <= PERIOD_W'(600);
            cfg_reg.pulse_half   <= HALF_W'(100);
            cfg_reg.reverse_dir  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_POS: cfg_reg.min_position <= $signed(cfg_wdata[POS_BITS-1:0]);
                REG_MAX_POS: cfg_reg.max_position <= $signed(cfg_wdata[POS_BITS-1:0]);
                REG_SCALE:   cfg_reg.step_scale   <= cfg_wdata[SCALE_W-1:0];
                REG_PERIOD:  cfg_reg.step_period  <= cfg_wdata[PERIOD_W-1:0];
                REG_HALF:    cfg_reg.pulse_half   <= cfg_wdata[HALF_W-1:0];
                REG_REVERSE: cfg_reg.reverse_dir  <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // room as long as the skid entry is free
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    stepgen_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .command     (s_tuser),
        .steps       ($signed(s_tdata[STEPS_W-1:0])),
        .home_sensor (s_tdata[STEPS_W]),
        .cfg         (cfg_reg),
        .res         (res_now)
    );

    // output register loads whenever it is empty or being drained
    assign out_load = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || s_accept;
            skid_valid_reg <= skid_valid_reg && s_accept;
        end
        else if (s_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (s_accept)
            begin
                out_reg <= res_now;
            end
        end
        if (s_accept && (skid_valid_reg || !out_load))
        begin
            skid_reg <= res_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.busy_res, out_reg.axis_position,
                       out_reg.awake_out, out_reg.dir_out, out_reg.step_out};
    assign m_tuser  = out_reg.status;

endmodule
